@@ rtl/mcf_pkg.sv @@
`timescale 1ns / 1ps

package mcf_pkg;

  localparam logic [7:0] SyncByte = 8'hA5;
  localparam logic [7:0] LenByte  = 8'h03;
  localparam logic [7:0] CmdCode  = 8'hF2;
  localparam logic [7:0] CrcPoly  = 8'h8C;
  localparam logic [7:0] RunBit   = 8'h01;
  localparam logic [7:0] DirBit   = 8'h02;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] spd_hi;
    logic [7:0] spd_lo;
    logic [7:0] crc;
  } mcf_frame_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [7:0] CrcHead = crc8_byte(crc8_byte(crc8_byte(8'h00, SyncByte), LenByte),
                                             CmdCode);

endpackage

@@ rtl/mcf_if.sv @@
`timescale 1ns / 1ps

interface mcf_cmd_if;
  logic        valid;
  logic        ready;
  logic        run;
  logic        direction;
  logic [15:0] speed;

  modport source (output valid, run, direction, speed, input ready);
  modport sink   (input valid, run, direction, speed, output ready);
endinterface

interface mcf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, frame_byte, last, input ready);
  modport sink   (input valid, frame_byte, last, output ready);
endinterface

@@ rtl/mcf_crc_pipe.sv @@
`timescale 1ns / 1ps

module mcf_crc_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               run_i,
  input  logic               direction_i,
  input  logic [15:0]        speed_i,
  output logic               valid_o,
  input  logic               ready_i,
  output mcf_pkg::mcf_frame_t frame_o
);
  import mcf_pkg::*;

  logic       v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  mcf_frame_t s1_q, s2_q, s3_q;
  logic [7:0] status_d;
  logic [7:0] crc1_d, crc2_d, crc3_d;

  assign rdy3 = !v3_q || ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign status_d = (run_i ? RunBit : 8'h00) | (direction_i ? DirBit : 8'h00);
  assign crc1_d   = crc8_byte(CrcHead, status_d);
  assign crc2_d   = crc8_byte(s1_q.crc, s1_q.spd_hi);
  assign crc3_d   = crc8_byte(s2_q.crc, s2_q.spd_lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      s1_q <= {status_d, speed_i, crc1_d};
    end
    if (rdy2 && v1_q) begin
      s2_q <= {s1_q.status, s1_q.spd_hi, s1_q.spd_lo, crc2_d};
    end
    if (rdy3 && v2_q) begin
      s3_q <= {s2_q.status, s2_q.spd_hi, s2_q.spd_lo, crc3_d};
    end
  end

  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign frame_o = s3_q;

endmodule

@@ rtl/motor_command_frame_crc8_top.sv @@
`timescale 1ns / 1ps

// Motor command framer. Each command transfer on cmd_i becomes a seven-byte frame on frm_o:
// 0xA5, 0x03, 0xF2, status (bit 0 run, bit 1 direction), speed high, speed low, and a
// reflected CRC-8 (poly 0x8C, init 0, no final xor) over the first six bytes, marked by last.
// A command passes through three CRC stages, one status or speed byte folded per stage,
// and then into the output register, from which its bytes are sent; bytes leave at one per
// cycle while the receiver is ready, and a new command enters the output register only once
// the last byte of the frame is taken, so the single byte output port limits the command
// rate. Up to three further commands are held in the CRC stages while a frame is sent.
module motor_command_frame_crc8_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcf_cmd_if.sink    cmd_i,
  mcf_byte_if.source frm_o
);
  import mcf_pkg::*;

  localparam logic [2:0] IdxSync   = 3'd0;
  localparam logic [2:0] IdxLen    = 3'd1;
  localparam logic [2:0] IdxCmd    = 3'd2;
  localparam logic [2:0] IdxStatus = 3'd3;
  localparam logic [2:0] IdxSpdHi  = 3'd4;
  localparam logic [2:0] IdxSpdLo  = 3'd5;
  localparam logic [2:0] IdxCrc    = 3'd6;

  logic       pipe_valid;
  logic       pipe_ready;
  mcf_frame_t pipe_frame;

  logic       busy_q;
  logic [2:0] idx_q;
  mcf_frame_t frm_q;
  logic       take;
  logic       at_last;

  mcf_crc_pipe u_crc_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cmd_i.valid),
    .ready_o     (cmd_i.ready),
    .run_i       (cmd_i.run),
    .direction_i (cmd_i.direction),
    .speed_i     (cmd_i.speed),
    .valid_o     (pipe_valid),
    .ready_i     (pipe_ready),
    .frame_o     (pipe_frame)
  );

  assign take       = busy_q && frm_o.ready;
  assign at_last    = (idx_q == IdxCrc);
  assign pipe_ready = !busy_q || (take && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= IdxSync;
    end else if (pipe_ready && pipe_valid) begin
      busy_q <= 1'b1;
      idx_q  <= IdxSync;
    end else if (take) begin
      if (at_last) begin
        busy_q <= 1'b0;
        idx_q  <= IdxSync;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_ready && pipe_valid) frm_q <= pipe_frame;
  end

  always_comb begin
    case (idx_q)
      IdxSync:   frm_o.frame_byte = SyncByte;
      IdxLen:    frm_o.frame_byte = LenByte;
      IdxCmd:    frm_o.frame_byte = CmdCode;
      IdxStatus: frm_o.frame_byte = frm_q.status;
      IdxSpdHi:  frm_o.frame_byte = frm_q.spd_hi;
      IdxSpdLo:  frm_o.frame_byte = frm_q.spd_lo;
      IdxCrc:    frm_o.frame_byte = frm_q.crc;
      default:   frm_o.frame_byte = 8'h00;
    endcase
  end

  assign frm_o.valid = busy_q;
  assign frm_o.last  = at_last;

endmodule

@@ bench/mcf_frame_checker.sv @@
`timescale 1ns / 1ps

module mcf_frame_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mcf_cmd_if   cmd_i,
  mcf_byte_if  frm_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [7:0] SYNC_BYTE = 8'hA5;
  localparam logic [7:0] LEN_BYTE  = 8'h03;
  localparam logic [7:0] CMD_BYTE  = 8'hF2;
  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam int         HEAD_LEN  = 6;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_frame_bytes [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [7:0] crc8_maxim_over(input logic [8*HEAD_LEN-1:0] msg);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = HEAD_LEN - 1; k >= 0; k--) begin
      acc = acc ^ msg[k*8 +: 8];
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  task automatic queue_frame(input logic run, input logic direction, input logic [15:0] speed);
    logic [8*HEAD_LEN-1:0] msg;
    frame_byte_t           entry;
    msg = {SYNC_BYTE, LEN_BYTE, CMD_BYTE, {6'b000000, direction, run}, speed};
    for (int k = HEAD_LEN - 1; k >= 0; k--) begin
      entry.frame_byte = msg[k*8 +: 8];
      entry.last       = 1'b0;
      expected_frame_bytes.push_back(entry);
    end
    entry.frame_byte = crc8_maxim_over(msg);
    entry.last       = 1'b1;
    expected_frame_bytes.push_back(entry);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] frame check error: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin : check_p
    frame_byte_t want;
    if (rst_ni) begin
      if (cmd_i.valid && cmd_i.ready) begin
        queue_frame(cmd_i.run, cmd_i.direction, cmd_i.speed);
      end
      if (frm_i.valid && frm_i.ready) begin
        if (expected_frame_bytes.size() == 0) begin
          report_mismatch($sformatf("byte 0x%02h last %0b with no frame pending",
                                    frm_i.frame_byte, frm_i.last));
        end else begin
          want = expected_frame_bytes.pop_front();
          if (frm_i.frame_byte !== want.frame_byte) begin
            report_mismatch($sformatf("frame_byte 0x%02h, want 0x%02h",
                                      frm_i.frame_byte, want.frame_byte));
          end
          if (frm_i.last !== want.last) begin
            report_mismatch($sformatf("last %0b, want %0b on byte 0x%02h",
                                      frm_i.last, want.last, want.frame_byte));
          end
        end
      end
      pending_o = expected_frame_bytes.size();
    end
  end

endmodule

@@ bench/tb_motor_command_frame_crc8_top.sv @@
`timescale 1ns / 1ps

module tb_motor_command_frame_crc8_top;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 20;
  localparam int HoldOffCycles = 90;
  localparam logic [7:0][15:0] CornerSpeed = {16'h1234, 16'hAAAA, 16'h5555, 16'hFF00,
                                              16'h00FF, 16'h0001, 16'h8000, 16'hFFFF};

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_req;

  mcf_cmd_if  cmd_bus ();
  mcf_byte_if frm_bus ();

  motor_command_frame_crc8_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus),
    .frm_o  (frm_bus)
  );

  mcf_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (cmd_bus),
    .frm_i        (frm_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_command(input logic run, input logic direction, input logic [15:0] speed);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.run       <= run;
    cmd_bus.direction <= direction;
    cmd_bus.speed     <= speed;
    do @(posedge clk); while (!cmd_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_random_command();
    logic [15:0] speed;
    speed = ($urandom_range(9) == 0) ? CornerSpeed[3'($urandom_range(7))]
                                     : 16'($urandom_range(65535));
    send_command(1'($urandom_range(1)), 1'($urandom_range(1)), speed);
  endtask

  task automatic pause_until_drained();
    cmd_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver_p
    int hold_left;
    hold_left     = 0;
    frm_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        frm_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        frm_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog_p
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (frm_bus.valid && frm_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus_p
    cmd_bus.valid     = 1'b0;
    cmd_bus.run       = 1'b0;
    cmd_bus.direction = 1'b0;
    cmd_bus.speed     = 16'h0000;
    hold_req          = 0;
    send_idle_pct     = 26;
    recv_idle_pct     = 45;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 16; i++) begin
      send_command(i[3], i[2], CornerSpeed[3'(i)]);
    end
    pause_until_drained();

    for (int i = 0; i < 80; i++) send_random_command();
    pause_until_drained();

    send_idle_pct = 45;
    recv_idle_pct = 26;
    for (int i = 0; i < 80; i++) send_random_command();
    pause_until_drained();

    // hold the output back while commands keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = HoldOffCycles;
    for (int i = 0; i < 80; i++) send_random_command();

    cmd_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
